// ----- rtl/tren_pkg.sv -----
// Shared types and constants of the tree root election node.
// Used by the child id RAM, the top level and the port checker.
// No dependencies.
package tren_pkg;

    localparam int MAX_CHILDREN = 16;
    localparam int ID_W         = 32;
    localparam int IDX_W        = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;
    localparam int CNT_W        = $clog2(MAX_CHILDREN + 1);
    localparam int COUNT_OUT_W  = 5;

    // stream payload widths
    localparam int S_DATA_W = 4 * ID_W;                   // 128
    localparam int M_DATA_W = 4 * ID_W + 1 + 2 + COUNT_OUT_W;  // 136

    localparam logic [ID_W-1:0] HEIGHT_MAX = '1;

    // input kind codes
    localparam logic KIND_RECV = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // child table change codes
    typedef logic [1:0] t_cchange;
    localparam t_cchange CC_NONE = 2'd0;
    localparam t_cchange CC_ADD  = 2'd1;
    localparam t_cchange CC_DEL  = 2'd2;
    localparam t_cchange CC_FULL = 2'd3;

    // request to the child id RAM
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [ID_W-1:0]  wr_data;
    } t_ram_req;

endpackage

// ----- rtl/tree_root_election_node.sv -----
// Top level of the tree root election node: parent adoption, child table scan, output beat.
// Depends on tren_pkg and tren_child_ram.
//
//  channel   | dir | handshake                          | payload
//  s_axis    | in  | i_s_axis_tvalid / o_s_axis_tready  | tdata 128b, tuser 1b
//  m_axis    | out | o_m_axis_tvalid / i_m_axis_tready  | tdata 136b, tuser 1b
//  cfg       | in  | i_cfg_valid / o_cfg_ready          | own_id 32b
//
// Tick: the item goes straight to S_EMIT, and the result beat is registered once the output is free.
// Received announcement: the item passes S_SCAN, S_DECIDE and S_EMIT in turn; S_SCAN is the
// one-entry-a-cycle scan of the child id RAM over all MAX_CHILDREN entries.
// One item in work at a time; the next is accepted while a result beat still waits.
// An own_id write is taken only between items and goes ahead of a waiting input beat.
// Sync active-low reset clears root, height, parent, own_id and the child valid bits.
module tree_root_election_node (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [31:0] sender_id, [63:32] sender_root, [95:64] sender_height, [127:96] sender_parent
    input  logic [tren_pkg::S_DATA_W-1:0]     i_s_axis_tdata,
    // [0] kind
    input  logic                              i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [31:0] node_id, [63:32] root_id, [95:64] parent_id, [127:96] hop_height,
    // [128] parent_changed, [130:129] child_change, [135:131] child_count
    output logic [tren_pkg::M_DATA_W-1:0]     o_m_axis_tdata,
    // [0] is_announce
    output logic                              o_m_axis_tuser,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tren_pkg::ID_W-1:0]         i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_EMIT
    } t_state;

    t_state r_state;

    logic [tren_pkg::ID_W-1:0]          r_own_id;
    logic [tren_pkg::ID_W-1:0]          r_root;
    logic [tren_pkg::ID_W-1:0]          r_height;
    logic [tren_pkg::ID_W-1:0]          r_parent;
    logic [tren_pkg::MAX_CHILDREN-1:0]  r_valid;
    logic [tren_pkg::CNT_W-1:0]         r_count;

    logic                               r_kind;
    logic [tren_pkg::ID_W-1:0]          r_sid;
    logic                               r_spa_mine;
    logic                               r_changed;
    tren_pkg::t_cchange                 r_cc;

    logic [tren_pkg::CNT_W-1:0]         r_idx;
    logic                               r_found;
    logic [tren_pkg::IDX_W-1:0]         r_fidx;
    logic                               r_free;
    logic [tren_pkg::IDX_W-1:0]         r_freeidx;

    logic                               r_m_valid;
    logic [tren_pkg::M_DATA_W-1:0]      r_m_data;
    logic                               r_m_user;

    tren_pkg::t_ram_req                 w_req;
    logic [tren_pkg::ID_W-1:0]          w_rd_data;

    logic [tren_pkg::ID_W-1:0]          w_sid;
    logic [tren_pkg::ID_W-1:0]          w_srt;
    logic [tren_pkg::ID_W-1:0]          w_sht;
    logic [tren_pkg::ID_W-1:0]          w_spa;
    logic [tren_pkg::ID_W-1:0]          w_cand;
    logic                               w_adopt;
    logic                               w_in_acc;
    logic                               w_cfg_acc;
    logic                               w_out_free;
    logic                               w_proc;
    logic [tren_pkg::CNT_W-1:0]         w_prev;
    logic [tren_pkg::IDX_W-1:0]         w_prev_idx;
    logic                               w_last;
    logic                               w_add;
    logic [tren_pkg::CNT_W+tren_pkg::COUNT_OUT_W-1:0] w_cnt_ext;

    assign w_sid = i_s_axis_tdata[31:0];
    assign w_srt = i_s_axis_tdata[63:32];
    assign w_sht = i_s_axis_tdata[95:64];
    assign w_spa = i_s_axis_tdata[127:96];

    assign w_cand  = (w_sht == tren_pkg::HEIGHT_MAX) ? tren_pkg::HEIGHT_MAX
                                                     : w_sht + tren_pkg::ID_W'(1);
    assign w_adopt = (w_srt > r_root) || ((w_srt == r_root) && (w_cand < r_height));

    // own_id writes only between items, ahead of an input beat
    assign o_cfg_ready     = (r_state == S_IDLE);
    assign o_s_axis_tready = (r_state == S_IDLE) && !i_cfg_valid;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cfg_acc       = i_cfg_valid && o_cfg_ready;
    assign w_out_free      = !r_m_valid || i_m_axis_tready;

    // scan: read address r_idx goes out while data of r_idx-1 is checked
    assign w_proc     = (r_state == S_SCAN) && (r_idx != '0);
    assign w_prev     = r_idx - tren_pkg::CNT_W'(1);
    assign w_prev_idx = w_prev[tren_pkg::IDX_W-1:0];
    assign w_last     = (r_idx == tren_pkg::CNT_W'(tren_pkg::MAX_CHILDREN));
    assign w_add      = !r_found && r_spa_mine && r_free;

    always_comb begin
        w_req.rd_en   = (r_state == S_SCAN) && !w_last;
        w_req.rd_addr = r_idx[tren_pkg::IDX_W-1:0];
        w_req.wr_en   = (r_state == S_DECIDE) && w_add;
        w_req.wr_addr = r_freeidx;
        w_req.wr_data = r_sid;
    end

    tren_child_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (w_req),
        .o_rd_data (w_rd_data)
    );

    assign w_cnt_ext = {{tren_pkg::COUNT_OUT_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_own_id  <= '0;
            r_root    <= '0;
            r_height  <= '0;
            r_parent  <= '0;
            r_valid   <= '0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (r_state == S_EMIT && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_kind     <= i_s_axis_tuser;
                        r_sid      <= w_sid;
                        r_spa_mine <= (w_spa == r_own_id);
                        r_changed  <= 1'b0;
                        r_cc       <= tren_pkg::CC_NONE;
                        r_idx      <= '0;
                        r_found    <= 1'b0;
                        r_free     <= 1'b0;
                        if (i_s_axis_tuser == tren_pkg::KIND_RECV) begin
                            if (w_adopt) begin
                                r_parent  <= w_sid;
                                r_height  <= w_cand;
                                r_root    <= w_srt;
                                r_changed <= 1'b1;
                            end
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_proc) begin
                        if (r_valid[w_prev_idx]) begin
                            if (!r_found && (w_rd_data == r_sid)) begin
                                r_found <= 1'b1;
                                r_fidx  <= w_prev_idx;
                            end
                        end else if (!r_free) begin
                            r_free    <= 1'b1;
                            r_freeidx <= w_prev_idx;
                        end
                    end
                    if (w_last) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_idx <= r_idx + tren_pkg::CNT_W'(1);
                    end
                end
                S_DECIDE: begin
                    if (!r_found && r_spa_mine) begin
                        if (r_free) begin
                            r_valid[r_freeidx] <= 1'b1;
                            r_count            <= r_count + tren_pkg::CNT_W'(1);
                            r_cc               <= tren_pkg::CC_ADD;
                        end else begin
                            r_cc <= tren_pkg::CC_FULL;
                        end
                    end else if (r_found && !r_spa_mine) begin
                        r_valid[r_fidx] <= 1'b0;
                        r_count         <= r_count - tren_pkg::CNT_W'(1);
                        r_cc            <= tren_pkg::CC_DEL;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_m_user <= r_kind;
                        r_m_data <= {w_cnt_ext[tren_pkg::COUNT_OUT_W-1:0], r_cc, r_changed,
                                     r_height, r_parent, r_root, r_own_id};
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // own_id write restarts the election at this node
            if (w_cfg_acc) begin
                r_own_id <= i_cfg_data;
                r_root   <= i_cfg_data;
                r_height <= '0;
                r_parent <= '0;
            end
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

endmodule

// ----- rtl/tren_child_ram.sv -----
// Child id store: one write port, one read port, registered read data.
// Depends on tren_pkg.
module tren_child_ram (
    input  logic                        i_clk,
    input  tren_pkg::t_ram_req          i_req,
    output logic [tren_pkg::ID_W-1:0]   o_rd_data
);

    logic [tren_pkg::ID_W-1:0] mem [tren_pkg::MAX_CHILDREN];
    logic [tren_pkg::ID_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/tren_checker.sv -----
// Port-level checker of the tree root election node, bound to the top level.
// Depends on tren_pkg and tree_root_election_node.
module tren_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    input  logic                              o_s_axis_tready,
    input  logic [tren_pkg::S_DATA_W-1:0]     i_s_axis_tdata,
    input  logic                              i_s_axis_tuser,
    input  logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic [tren_pkg::M_DATA_W-1:0]     o_m_axis_tdata,
    input  logic                              o_m_axis_tuser,
    input  logic                              i_cfg_valid,
    input  logic                              o_cfg_ready,
    input  logic [tren_pkg::ID_W-1:0]         i_cfg_data
);

    localparam logic [tren_pkg::CNT_W+tren_pkg::COUNT_OUT_W-1:0] FULL_EXT =
        (tren_pkg::CNT_W+tren_pkg::COUNT_OUT_W)'(tren_pkg::MAX_CHILDREN);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result beat changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input accepted on consecutive cycles");

    // a tick never reports parent or child changes
    a_tick_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata[130:128] == 3'b000)
        else $error("tick result carries change flags");

    // a dropped add only happens with the table full
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[130:129] == tren_pkg::CC_FULL) |->
            o_m_axis_tdata[135:131] == FULL_EXT[tren_pkg::COUNT_OUT_W-1:0])
        else $error("add dropped while table not full");

endmodule

bind tree_root_election_node tren_checker u_tren_checker (.*);
